FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on i_clk and is
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mpfd_pkg.sv
package mpfd_pkg;

    // Mode register codes
    localparam logic [2:0] MODE_STREAM  = 3'd0;
    localparam logic [2:0] MODE_CHUNKED = 3'd1;
    localparam logic [2:0] MODE_DOLLAR  = 3'd2;
    localparam logic [2:0] MODE_LEN4    = 3'd3;
    localparam logic [2:0] MODE_LEN2    = 3'd4;

    // Register indexes (bit 2 of the byte address)
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_MAX_FRAME = 1'b1;

    localparam logic [31:0] MAX_FRAME_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        ST_MORE       = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_BAD_MARKER = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_OVER_MAX   = 3'd4,
        ST_BAD_MODE   = 3'd5
    } t_status;

    // Per-frame parse state, cleared after every completion or error
    typedef struct packed {
        logic [31:0] count;      // bytes of the frame so far
        logic [7:0]  prev;       // previous byte
        logic [31:0] length;     // length being built
        logic [31:0] hdr_size;   // chunked: size line length, zero while open
        logic        hex_stop;   // chunked: size digits done
        logic [33:0] frame_end;  // total frame bytes once the header is known
    } t_frame_state;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [31:0] position;
        logic        in_header;
        t_status     status;
        logic [31:0] header_length;
        logic [31:0] body_length;
    } t_result;

endpackage

FILE: rtl/mpfd_step.sv
module mpfd_step (
    input  logic [2:0]            i_mode,
    input  logic [31:0]           i_max_frame,
    input  mpfd_pkg::t_frame_state i_state,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_burst_end,
    output mpfd_pkg::t_frame_state o_next,
    output mpfd_pkg::t_result     o_res
);
    import mpfd_pkg::*;

    localparam logic [7:0]  CH_DOLLAR  = 8'h24;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [31:0] LEN4_LIMIT = 32'h00FF_FFFF;
    localparam logic [31:0] LEN2_LIMIT = 32'h0000_FFFF;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [32:0] n;
    logic [32:0] mx;
    logic [4:0]  hex;
    logic [2:0]  hdr_len;
    logic [31:0] lf_shift;
    logic [33:0] chunk_sum;
    logic [33:0] chunk_end;
    logic [33:0] hdr_sum;
    logic        hdr_byte;

    assign n         = {1'b0, i_state.count} + 33'd1;
    assign mx        = {1'b0, i_max_frame};
    assign hex       = hex_digit(i_data_byte);
    assign hdr_len   = (i_mode == MODE_LEN2) ? 3'd2 : 3'd4;
    assign lf_shift  = {i_state.length[23:0], i_data_byte};
    assign chunk_sum = {2'b0, i_state.count} + {2'b0, i_state.length} + 34'd1;
    assign chunk_end = {2'b0, i_state.count} + {2'b0, i_state.length} + 34'd3;
    assign hdr_sum   = {2'b0, lf_shift} + {31'b0, hdr_len};
    assign hdr_byte  = i_state.count < {29'b0, hdr_len};

    always_comb begin
        o_next              = i_state;
        o_res.byte_out      = i_data_byte;
        o_res.position      = i_state.count;
        o_res.in_header     = 1'b0;
        o_res.status        = ST_MORE;
        o_res.header_length = '0;
        o_res.body_length   = '0;

        unique case (i_mode)
            MODE_STREAM: begin
                if (i_burst_end || n >= mx) begin
                    o_res.status      = ST_COMPLETE;
                    o_res.body_length = n[31:0];
                end
            end
            MODE_CHUNKED: begin
                o_res.in_header = (i_state.hdr_size == '0);
                if (n > mx) begin
                    o_res.status = ST_OVER_MAX;
                end else if (i_state.hdr_size == '0) begin
                    if (i_state.prev == CH_CR && i_data_byte == CH_LF) begin
                        o_next.hdr_size  = n[31:0];
                        o_next.frame_end = chunk_end;
                        if (chunk_sum > {1'b0, mx}) begin
                            o_res.status = ST_BAD_LENGTH;
                        end
                    end else if (!i_state.hex_stop) begin
                        if (!hex[4]) begin
                            o_next.hex_stop = 1'b1;
                        end else if (i_state.length[31:28] != 4'd0) begin
                            o_res.status = ST_BAD_LENGTH;
                        end else begin
                            o_next.length = {i_state.length[27:0], hex[3:0]};
                        end
                    end
                end else if ({1'b0, n} >= i_state.frame_end) begin
                    o_res.status        = ST_COMPLETE;
                    o_res.header_length = i_state.hdr_size;
                    o_res.body_length   = i_state.length;
                end
            end
            MODE_DOLLAR, MODE_LEN4, MODE_LEN2: begin
                o_res.in_header = hdr_byte;
                if (n > mx) begin
                    o_res.status = ST_OVER_MAX;
                end else if (hdr_byte) begin
                    if (i_mode == MODE_DOLLAR && i_state.count == '0
                        && i_data_byte != CH_DOLLAR) begin
                        o_res.status = ST_BAD_MARKER;
                    end else begin
                        // interleaved: skip marker and channel bytes
                        if (i_mode != MODE_DOLLAR || i_state.count >= 32'd2) begin
                            o_next.length = lf_shift;
                        end
                        if (n == {30'b0, hdr_len}) begin
                            o_next.frame_end = hdr_sum;
                            if (i_mode == MODE_LEN4
                                && (lf_shift == '0 || lf_shift > LEN4_LIMIT)) begin
                                o_res.status = ST_BAD_LENGTH;
                            end else if (i_mode == MODE_LEN2
                                && (lf_shift == '0 || lf_shift > LEN2_LIMIT)) begin
                                o_res.status = ST_BAD_LENGTH;
                            end else if (hdr_sum > {1'b0, mx}) begin
                                o_res.status = ST_BAD_LENGTH;
                            end else if (lf_shift == '0) begin
                                o_res.status        = ST_COMPLETE;
                                o_res.header_length = {29'b0, hdr_len};
                            end
                        end
                    end
                end else if ({1'b0, n} >= i_state.frame_end) begin
                    o_res.status        = ST_COMPLETE;
                    o_res.header_length = {29'b0, hdr_len};
                    o_res.body_length   = i_state.length;
                end
            end
            default: begin
                o_res.status = ST_BAD_MODE;
            end
        endcase

        if (o_res.status != ST_MORE) begin
            o_next = '0;
        end else begin
            o_next.count = n[31:0];
            o_next.prev  = i_data_byte;
        end
    end

endmodule

FILE: rtl/multi_protocol_frame_delimiter_core.sv
// Path: an accepted byte passes through the input register, then the result
// register, from which its result word leaves. Throughput: one byte per
// cycle while i_out_stall is low; the next byte is taken while a result waits.
// Reset: synchronous, active low; clears frame state, mode (stream) and sets
// max_frame to 65536. Both pipeline stages come out empty.
`include "assert_macros.svh"

module multi_protocol_frame_delimiter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_burst_end,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_byte_out,
    output logic [31:0] o_position,
    output logic        o_in_header,
    output logic [2:0]  o_status,
    output logic [31:0] o_header_length,
    output logic [31:0] o_body_length,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mpfd_pkg::*;

    // Configuration registers
    logic [2:0]   r_mode;
    logic [31:0]  r_max_frame;

    // Frame parse state, advanced once per byte leaving the input stage
    t_frame_state r_st;
    t_frame_state n_st;

    // Input stage
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_be;

    // Result stage
    logic         r_out_valid;
    t_result      r_res;
    t_result      n_res;

    logic         cfg_wr;
    logic         out_ready;
    logic         step_fire;
    logic         in_accept;

    // Register write completes in the access phase; no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_FRAME) ? r_max_frame : {29'b0, r_mode};

    // The result register frees up when empty or when its word is taken;
    // the input stage then moves forward in the same cycle.
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign step_fire  = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    // All per-byte decisions: compares, the count increment and end-of-frame
    // sums computed in parallel, and the hex shift-accumulate.
    mpfd_step u_step (
        .i_mode      (r_mode),
        .i_max_frame (r_max_frame),
        .i_state     (r_st),
        .i_data_byte (r_in_byte),
        .i_burst_end (r_in_be),
        .o_next      (n_st),
        .o_res       (n_res)
    );

    // Control state: config, frame state, stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STREAM;
            r_max_frame <= MAX_FRAME_RESET;
            r_st        <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_MODE) begin
                r_mode <= pwdata[2:0];
            end
            if (cfg_wr && paddr[2] == REG_MAX_FRAME) begin
                r_max_frame <= pwdata;
            end

            // A mode write drops the frame in progress.
            if (cfg_wr && paddr[2] == REG_MODE) begin
                r_st <= '0;
            end else if (step_fire) begin
                r_st <= n_st;
            end

            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end

            if (step_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled, load on advance
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_be   <= i_burst_end;
        end
        if (step_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_res.byte_out;
    assign o_position      = r_res.position;
    assign o_in_header     = r_res.in_header;
    assign o_status        = r_res.status;
    assign o_header_length = r_res.header_length;
    assign o_body_length   = r_res.body_length;

    // Lengths are reported only with a completed frame.
    `ASSERT_IMPLY(a_len_only_on_done, r_out_valid && (r_res.status != ST_COMPLETE), (r_res.header_length == '0) && (r_res.body_length == '0), "frame lengths set on a word that does not complete a frame")
    // A completion or an error restarts the frame at offset zero.
    `ASSERT_NEXT(a_restart_after_end, step_fire && (n_res.status != ST_MORE), r_st.count == '0, "frame count not cleared after frame end")
    // A blocked input stage keeps its word.
    `ASSERT_NEXT(a_in_stage_hold, r_in_valid && !out_ready, r_in_valid && $stable(r_in_byte) && $stable(r_in_be), "input stage word lost while blocked")

endmodule
